FILE: hw/rtl/pal_pkg.sv
package pal_pkg;

   // List capacity and the widths that follow from it.
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths of the request and the result.
   localparam int FUNC_W   = 2;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;

   // Width used to compare positions against the entry count without overflow.
   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_BITS = FUNC_W + POS_W + DATA_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = STATUS_W + DATA_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_DUMP   = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE    = 3'd0,
      STAT_FULL    = 3'd1,
      STAT_EMPTY   = 3'd2,
      STAT_INVALID = 3'd3,
      STAT_ENTRY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SH_RD,
      S_SH_WR,
      S_PUT,
      S_RESP,
      S_DUMP_RD,
      S_DUMP_OUT
   } state_type;

endpackage

FILE: hw/rtl/pal_ram.sv
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/positional_array_list.sv
// Ordered list of up to DEPTH signed 32-bit values held in a single-port-write,
// registered-read RAM, with a count of valid entries. A request carries func
// (insert, delete or dump), a 1-based position and a value. An insert at
// position p (1 to count+1) moves entries p..count up by one and stores the
// value; a delete at p (1 to count) moves entries p+1..count down by one. Each
// moved entry is read from its neighbor slot in one state and written in the
// next, once the RAM's registered read data is back. A stalled output holds
// the sequencer in its result state until the register frees. A dump returns
// every entry in order, reading the next one only once the last has gone into
// the output register, with tlast on the final one. A dump of an empty list and
// every other request yield exactly one result with tlast set: status done,
// full, empty or invalid position (unused func code 3 counts as invalid). The
// block takes one request at a time and accepts a new one as soon as its
// sequencer is idle, even while the last result still waits in the output
// register. The list RAM is not cleared at reset; only entries below the count
// are read.
module positional_array_list (
   input  logic                       clock,
   input  logic                       reset,
   // Request stream.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // req_tdata fields from bit 0: func[1:0], position[8:2], new_value[40:9].
   input  logic [pal_pkg::REQ_W-1:0]  req_tdata,
   // Result stream.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // rsp_tdata fields from bit 0: status[2:0], entry_value[34:3].
   output logic [pal_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                       rsp_tlast
);

   import pal_pkg::*;

   // Sequencer state and the captured request.
   state_type           state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   val_ff, val_in;

   // List bookkeeping and the shared walking index.
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   status_type          status_ff, status_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_load;

   // RAM port.
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [DATA_W-1:0]   ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [DATA_W-1:0]   ram_rdata;

   // Decisions shared by the next-state and output logic.
   logic [CMP_W-1:0]    pos_x, count_x, idx_x;
   logic                req_accept, out_free, is_insert;
   logic                list_full, list_empty, ins_bad, del_bad;
   logic                ins_no_shift, del_no_shift, ins_stop, del_stop, dump_last;

   pal_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_insert  = (func_ff == FUNC_INSERT);

   assign pos_x   = CMP_W'(pos_ff);
   assign count_x = CMP_W'(count_ff);
   assign idx_x   = CMP_W'(idx_ff);

   assign list_full    = (count_x == CMP_W'(DEPTH));
   assign list_empty   = (count_ff == '0);
   assign ins_bad      = (pos_ff == '0) || (pos_x > count_x + CMP_W'(1));
   assign del_bad      = (pos_ff == '0) || (pos_x > count_x);
   assign ins_no_shift = (pos_x == count_x + CMP_W'(1));
   assign del_no_shift = (pos_x == count_x);
   assign ins_stop     = (idx_x == pos_x);
   assign del_stop     = (idx_x + CMP_W'(2) == count_x);
   assign dump_last    = (idx_x + CMP_W'(1) == count_x);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (func_ff)
               FUNC_INSERT: begin
                  if (list_full || ins_bad) begin
                     state_in = S_RESP;
                  end else if (ins_no_shift) begin
                     state_in = S_PUT;
                  end else begin
                     state_in = S_SH_RD;
                  end
               end
               FUNC_DELETE: begin
                  if (list_empty || del_bad || del_no_shift) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_SH_RD;
                  end
               end
               FUNC_DUMP: begin
                  state_in = list_empty ? S_RESP : S_DUMP_RD;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SH_RD: begin
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            if (is_insert) begin
               state_in = ins_stop ? S_PUT : S_SH_RD;
            end else begin
               state_in = del_stop ? S_RESP : S_SH_RD;
            end
         end
         S_PUT: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            state_in = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            if (out_free) begin
               state_in = dump_last ? S_IDLE : S_DUMP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath control: request capture, index walk, RAM port, result load.
   always_comb begin
      func_in       = func_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = idx_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in = req_tdata[FUNC_W-1:0];
               pos_in  = req_tdata[FUNC_W+POS_W-1:FUNC_W];
               val_in  = req_tdata[REQ_BITS-1:FUNC_W+POS_W];
            end
         end
         S_CHECK: begin
            case (func_ff)
               FUNC_INSERT: begin
                  if (list_full) begin
                     status_in = STAT_FULL;
                  end else if (ins_bad) begin
                     status_in = STAT_INVALID;
                  end else begin
                     // Walk down from the first free slot.
                     idx_in = ADDR_W'(count_ff);
                  end
               end
               FUNC_DELETE: begin
                  if (list_empty) begin
                     status_in = STAT_EMPTY;
                  end else if (del_bad) begin
                     status_in = STAT_INVALID;
                  end else if (del_no_shift) begin
                     // Removing the tail entry needs no moves.
                     status_in = STAT_DONE;
                     count_in  = count_ff - CNT_W'(1);
                  end else begin
                     idx_in = ADDR_W'(pos_ff - POS_W'(1));
                  end
               end
               FUNC_DUMP: begin
                  status_in = STAT_EMPTY;
                  idx_in    = '0;
               end
               default: begin
                  status_in = STAT_INVALID;
               end
            endcase
         end
         S_SH_RD: begin
            // Fetch the neighbor that moves into slot idx.
            ram_raddr = is_insert ? (idx_ff - ADDR_W'(1)) : (idx_ff + ADDR_W'(1));
         end
         S_SH_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            if (is_insert) begin
               idx_in = idx_ff - ADDR_W'(1);
            end else if (del_stop) begin
               status_in = STAT_DONE;
               count_in  = count_ff - CNT_W'(1);
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(pos_ff - POS_W'(1));
            ram_wdata = val_ff;
            count_in  = count_ff + CNT_W'(1);
            status_in = STAT_DONE;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
            end
         end
         S_DUMP_RD: begin
            ram_raddr = idx_ff;
         end
         S_DUMP_OUT: begin
            // Address held so the read data stays put while the output stalls.
            ram_raddr = idx_ff;
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = STAT_ENTRY;
               rsp_value_in  = ram_rdata;
               rsp_last_in   = dump_last;
               idx_in        = idx_ff + ADDR_W'(1);
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_value_ff, rsp_status_ff});
   assign rsp_tlast  = rsp_last_ff;

   // The entry count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_x <= CMP_W'(DEPTH))
      else $error("entry count above capacity");

   // Storing a new value grows the list by exactly one entry.
   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list by one");

   // A dump only reads the list; it never writes the RAM.
   a_dump_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DUMP_RD) || (state_ff == S_DUMP_OUT)) |-> !ram_we)
      else $error("RAM written during a dump");

   // A new result is loaded only when the output register can take it.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_status_ff == $past(rsp_status_ff)))
      else $error("pending result overwritten");

endmodule
